>>> sv/ccpa_pkg.sv
`default_nettype none
package ccpa_pkg;

    localparam int CAP_W  = 16;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 32;
    localparam int CH_W   = 2;
    localparam int MAX_CH = 4;

    localparam logic [CNT_W-1:0] AVG_COUNT_RESET = 16'd16;

    typedef logic [CAP_W-1:0] t_cap;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [SUM_W-1:0] t_sum;
    typedef logic [CH_W-1:0]  t_ch;

    typedef struct packed {
        t_ch  filter_select;
        logic result_updated;
        t_ch  updated_channel;
        t_cap red_period;
        t_cap green_period;
        t_cap blue_period;
        t_cap clear_period;
    } t_result;

endpackage
`default_nettype wire

>>> sv/ccpa_if.sv
`default_nettype none
interface ccpa_cap_if;
    import ccpa_pkg::*;

    logic valid;
    logic ready;
    t_cap capture_value;

    modport source (output valid, output capture_value, input ready);
    modport sink   (input valid, input capture_value, output ready);
endinterface

interface ccpa_res_if;
    import ccpa_pkg::*;

    logic valid;
    logic ready;
    t_ch  filter_select;
    logic result_updated;
    t_ch  updated_channel;
    t_cap red_period;
    t_cap green_period;
    t_cap blue_period;
    t_cap clear_period;

    modport source (
        output valid, output filter_select, output result_updated,
        output updated_channel, output red_period, output green_period,
        output blue_period, output clear_period, input ready
    );
    modport sink (
        input valid, input filter_select, input result_updated,
        input updated_channel, input red_period, input green_period,
        input blue_period, input clear_period, output ready
    );
endinterface
`default_nettype wire

>>> sv/color_channel_period_averager.sv
`default_nettype none
// Colour channel period averager: takes one 16-bit timer capture per transaction, adds the
// wrapped period since the previous capture to a running sum, and after average_count
// periods stores the sum shifted right by SUM_SHIFT (saturated at 65535) for the active
// channel, then steps to the next of NUM_CHANNELS channels. Each capture yields exactly one
// result carrying the filter select, the update flag and channel, and all four stored
// periods. One capture can be taken every clock cycle while results are taken; a stalled
// result register holds the input back. A capture is held in the input register until the core
// takes it and loads its result, the update being a single add, compare and store between the input register
// and the result register. average_count resets to 16 and is written through the
// configuration channel, which is always ready; write it only while no capture is in flight.
module color_channel_period_averager #(
    parameter int NUM_CHANNELS = 4,
    parameter int SUM_SHIFT    = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ccpa_cap_if.sink       i_cap,
    ccpa_res_if.source     o_res,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  ccpa_pkg::t_cnt i_cfg_data
);
    import ccpa_pkg::*;

    logic    in_valid;
    t_cap    in_cap;
    logic    take;
    logic    out_free;
    t_result result;

    assign o_cfg_ready = 1'b1;

    ccpa_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cap   (i_cap),
        .i_take  (take),
        .o_valid (in_valid),
        .o_cap   (in_cap)
    );

    ccpa_core #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .SUM_SHIFT    (SUM_SHIFT)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_cap      (in_cap),
        .i_out_free (out_free),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_data (i_cfg_data),
        .o_take     (take),
        .o_result   (result)
    );

    ccpa_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (take),
        .i_result (result),
        .o_free   (out_free),
        .o_res    (o_res)
    );
endmodule
`default_nettype wire

>>> sv/ccpa_in_stage.sv
`default_nettype none
module ccpa_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ccpa_cap_if.sink      i_cap,
    input  logic          i_take,
    output logic          o_valid,
    output ccpa_pkg::t_cap o_cap
);
    import ccpa_pkg::*;

    logic r_valid;
    t_cap r_cap;
    logic ready;

    // register empties whenever the core takes its transaction
    assign ready       = !r_valid || i_take;
    assign i_cap.ready = ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (ready) begin
            r_valid <= i_cap.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready && i_cap.valid) begin
            r_cap <= i_cap.capture_value;
        end
    end

    assign o_valid = r_valid;
    assign o_cap   = r_cap;
endmodule
`default_nettype wire

>>> sv/ccpa_core.sv
`default_nettype none
module ccpa_core #(
    parameter int NUM_CHANNELS = 4,
    parameter int SUM_SHIFT    = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  ccpa_pkg::t_cap    i_cap,
    input  logic              i_out_free,
    input  logic              i_cfg_we,
    input  ccpa_pkg::t_cnt    i_cfg_data,
    output logic              o_take,
    output ccpa_pkg::t_result o_result
);
    import ccpa_pkg::*;

    localparam t_ch CH_LAST = CH_W'(NUM_CHANNELS - 1);

    t_cnt r_avg_count;
    t_cap r_prev;
    t_cnt r_count;
    t_sum r_sum;
    t_ch  r_ch;
    t_cap r_periods [MAX_CH];

    t_cap n_prev;
    t_cnt n_count;
    t_sum n_sum;
    t_ch  n_ch;
    t_cap n_periods [MAX_CH];

    t_cap period;
    t_sum sum_add;
    t_cnt cnt_inc;
    t_sum shifted;
    t_cap avg;
    t_ch  ch_next;
    logic hit;
    logic take;

    assign take   = i_valid && i_out_free;
    assign o_take = take;

    always_comb begin
        period  = i_cap - r_prev;
        sum_add = r_sum + {{(SUM_W-CAP_W){1'b0}}, period};
        cnt_inc = r_count + 1'b1;
        hit     = (cnt_inc == r_avg_count);
        shifted = sum_add >> SUM_SHIFT;
        // saturate once anything above the low 16 bits survives the shift
        avg     = (|shifted[SUM_W-1:CAP_W]) ? '1 : shifted[CAP_W-1:0];
        ch_next = (r_ch == CH_LAST) ? '0 : t_ch'(r_ch + 1'b1);

        n_prev    = i_cap;
        n_count   = hit ? '0 : cnt_inc;
        n_sum     = hit ? '0 : sum_add;
        n_ch      = hit ? ch_next : r_ch;
        n_periods = r_periods;
        if (hit) begin
            n_periods[r_ch] = avg;
        end

        o_result.filter_select   = n_ch;
        o_result.result_updated  = hit;
        o_result.updated_channel = hit ? r_ch : '0;
        o_result.red_period      = n_periods[0];
        o_result.green_period    = n_periods[1];
        o_result.blue_period     = n_periods[2];
        o_result.clear_period    = n_periods[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg_count <= AVG_COUNT_RESET;
        end else if (i_cfg_we) begin
            r_avg_count <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev    <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_ch      <= '0;
            r_periods <= '{default: '0};
        end else if (take) begin
            r_prev    <= n_prev;
            r_count   <= n_count;
            r_sum     <= n_sum;
            r_ch      <= n_ch;
            r_periods <= n_periods;
        end
    end
endmodule
`default_nettype wire

>>> sv/ccpa_out_stage.sv
`default_nettype none
module ccpa_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ccpa_pkg::t_result i_result,
    output logic              o_free,
    ccpa_res_if.source        o_res
);
    import ccpa_pkg::*;

    logic    r_valid;
    t_result r_result;
    logic    free;

    assign free   = !r_valid || o_res.ready;
    assign o_free = free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_res.valid           = r_valid;
    assign o_res.filter_select   = r_result.filter_select;
    assign o_res.result_updated  = r_result.result_updated;
    assign o_res.updated_channel = r_result.updated_channel;
    assign o_res.red_period      = r_result.red_period;
    assign o_res.green_period    = r_result.green_period;
    assign o_res.blue_period     = r_result.blue_period;
    assign o_res.clear_period    = r_result.clear_period;
endmodule
`default_nettype wire

>>> sv/ccpa_checker.sv
`default_nettype none
module ccpa_checker #(
    parameter int NUM_CHANNELS = 4
) (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic [1:0] i_filter_select,
    input logic       i_result_updated,
    input logic [1:0] i_updated_channel
);
    localparam logic [1:0] CH_LAST = 2'(NUM_CHANNELS - 1);

    // a stalled result transaction stays offered
    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_res_ready) |=> i_res_valid)
        else $error("result valid dropped while stalled");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_idle_channel_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && !i_result_updated) |-> (i_updated_channel == 2'd0))
        else $error("updated channel nonzero without update");

    // after an update the filter select has moved to the following channel
    a_rotate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res_valid && i_result_updated) |->
        (((i_updated_channel == CH_LAST) && (i_filter_select == 2'd0)) ||
         ((i_updated_channel != CH_LAST) &&
          (i_filter_select == 2'(i_updated_channel + 2'd1)))))
        else $error("filter select did not rotate");
endmodule

bind color_channel_period_averager ccpa_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_ccpa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_res_valid       (o_res.valid),
    .i_res_ready       (o_res.ready),
    .i_filter_select   (o_res.filter_select),
    .i_result_updated  (o_res.result_updated),
    .i_updated_channel (o_res.updated_channel)
);
`default_nettype wire

>>> verif/tb.sv
`default_nettype none
module tb;
    import ccpa_pkg::*;

    localparam int NUM_CHANNELS = 4;
    localparam int SUM_SHIFT    = 4;
    localparam longint TIMEOUT  = 48_000_000;

    typedef enum logic [1:0] {
        GAP_SMALL,
        GAP_LARGE,
        GAP_MIXED
    } t_gap_mode;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_valid;
    logic o_cfg_ready;
    t_cnt i_cfg_data;

    ccpa_cap_if cap_if ();
    ccpa_res_if res_if ();

    color_channel_period_averager #(
        .NUM_CHANNELS(NUM_CHANNELS),
        .SUM_SHIFT   (SUM_SHIFT)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cap      (cap_if),
        .o_res      (res_if),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    // averager model state
    t_cnt avg_count;
    t_cap prev_cap;
    t_cnt period_cnt;
    t_sum period_sum;
    t_ch  active_ch;
    t_cap stored_period [MAX_CH];

    t_cap    pending_captures [$];
    t_result expected_results [$];
    t_result predicted;
    t_result observed;
    t_result oldest;
    t_cap    gen_prev;

    bit allow_idle;
    int send_gap;
    int stall_left;
    int error_count;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT);
        $display("Verification failed");
        $finish;
    end

    task automatic average_capture(input t_cap cap, output t_result r);
        t_cap period;
        t_sum avg;
        period = cap - prev_cap;
        prev_cap = cap;
        period_sum = period_sum + period;
        period_cnt = period_cnt + 1'b1;
        r.result_updated  = 1'b0;
        r.updated_channel = '0;
        if (period_cnt == avg_count) begin
            avg = period_sum >> SUM_SHIFT;
            if (avg > 32'h0000_FFFF) avg = 32'h0000_FFFF;
            period_cnt = '0;
            stored_period[active_ch] = avg[CAP_W-1:0];
            period_sum = '0;
            r.result_updated  = 1'b1;
            r.updated_channel = active_ch;
            active_ch = (int'(active_ch) == NUM_CHANNELS - 1) ? t_ch'(0) : active_ch + 1'b1;
        end
        r.filter_select = active_ch;
        r.red_period    = stored_period[0];
        r.green_period  = stored_period[1];
        r.blue_period   = stored_period[2];
        r.clear_period  = stored_period[3];
    endtask

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            error_count++;
        end
    endfunction

    // capture driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cap_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (cap_if.valid && cap_if.ready) begin
                average_capture(cap_if.capture_value, predicted);
                expected_results.push_back(predicted);
            end
            if (cap_if.valid && !cap_if.ready) begin
                // hold the transaction until it is taken
            end else if (send_gap > 0) begin
                send_gap--;
                cap_if.valid <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 11) == 0) begin
                send_gap = $urandom_range(1, 19) - 1;
                cap_if.valid <= 1'b0;
            end else if (pending_captures.size() != 0) begin
                cap_if.valid         <= 1'b1;
                cap_if.capture_value <= pending_captures.pop_front();
            end else begin
                cap_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                observed.filter_select   = res_if.filter_select;
                observed.result_updated  = res_if.result_updated;
                observed.updated_channel = res_if.updated_channel;
                observed.red_period      = res_if.red_period;
                observed.green_period    = res_if.green_period;
                observed.blue_period     = res_if.blue_period;
                observed.clear_period    = res_if.clear_period;
                if (expected_results.size() == 0) begin
                    $display("%0t: result with nothing expected, actual %h", $time, observed);
                    error_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("filter_select", oldest.filter_select, observed.filter_select);
                    check_field("result_updated", oldest.result_updated,
                                observed.result_updated);
                    check_field("updated_channel", oldest.updated_channel,
                                observed.updated_channel);
                    check_field("red_period", oldest.red_period, observed.red_period);
                    check_field("green_period", oldest.green_period, observed.green_period);
                    check_field("blue_period", oldest.blue_period, observed.blue_period);
                    check_field("clear_period", oldest.clear_period, observed.clear_period);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (allow_idle && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // sampled at the falling edge so the driver's updates have settled
    task automatic wait_drained();
        while (pending_captures.size() != 0 || cap_if.valid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_average_count(input t_cnt value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        avg_count = value;
    endtask

    task automatic queue_captures(input int count, input t_gap_mode mode);
        int   r;
        t_cap cap;
        @(negedge i_clk);
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 9);
            if (mode == GAP_MIXED && r < 3) begin
                cap = t_cap'($urandom);
            end else if (mode == GAP_LARGE || (mode == GAP_MIXED && r < 5)) begin
                cap = gen_prev + t_cap'($urandom_range(60000, 65535));
            end else begin
                cap = gen_prev + t_cap'($urandom_range(0, 400));
            end
            gen_prev = cap;
            pending_captures.push_back(cap);
        end
    endtask

    initial begin
        t_cap first_set [16] = '{16'h0000, 16'hFFFF, 16'h0000, 16'h8000,
                                 16'h7FFF, 16'h0001, 16'hFFFE, 16'h5555,
                                 16'hAAAA, 16'h00FF, 16'hFF00, 16'h1234,
                                 16'h1300, 16'h1400, 16'h1500, 16'h1600};
        t_cap walk_set [4] = '{16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555};
        int   sel;
        t_cnt count;

        i_rst_n              = 1'b0;
        i_cfg_valid          = 1'b0;
        i_cfg_data           = '0;
        cap_if.valid         = 1'b0;
        cap_if.capture_value = '0;
        res_if.ready         = 1'b0;
        allow_idle           = 1'b1;
        error_count          = 0;
        gen_prev             = '0;

        avg_count  = AVG_COUNT_RESET;
        prev_cap   = '0;
        period_cnt = '0;
        period_sum = '0;
        active_ch  = '0;
        for (int i = 0; i < MAX_CH; i++) stored_period[i] = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset count of 16, first period measured from zero, wrapped periods
        @(negedge i_clk);
        foreach (first_set[i]) pending_captures.push_back(first_set[i]);
        wait_drained();

        // count of one, every capture walks to the next channel
        write_average_count(16'd1);
        @(negedge i_clk);
        foreach (walk_set[i]) pending_captures.push_back(walk_set[i]);
        gen_prev = walk_set[3];
        wait_drained();

        for (int p = 0; p < 20; p++) begin
            sel = $urandom_range(0, 9);
            if (sel < 6) begin
                count = t_cnt'($urandom_range(1, 6));
                write_average_count(count);
                queue_captures($urandom_range(25, 45), GAP_MIXED);
            end else if (sel < 8) begin
                count = t_cnt'($urandom_range(7, 20));
                write_average_count(count);
                queue_captures($urandom_range(25, 45), GAP_MIXED);
            end else begin
                // long runs of large periods push the shifted sum past saturation
                count = t_cnt'($urandom_range(20, 70));
                write_average_count(count);
                queue_captures($urandom_range(25, 45), GAP_LARGE);
            end
            wait_drained();
        end

        allow_idle = 1'b0;

        // count zero: the counter would have to wrap, so nothing is stored here
        write_average_count(16'd0);
        queue_captures(40, GAP_MIXED);
        wait_drained();

        // count lowered below progress: counter runs on past the new value
        write_average_count(16'd1);
        queue_captures(1, GAP_SMALL);
        wait_drained();
        write_average_count(16'd16);
        queue_captures(10, GAP_SMALL);
        wait_drained();
        write_average_count(16'd3);
        queue_captures(40, GAP_SMALL);
        wait_drained();

        // largest count with the largest periods
        write_average_count(16'hFFFF);
        queue_captures(40, GAP_LARGE);
        wait_drained();

        write_average_count(t_cnt'($urandom_range(1, 3)));
        queue_captures(40, GAP_MIXED);
        wait_drained();
        repeat (10) @(posedge i_clk);

        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
`default_nettype wire

>>> sim.f
sv/ccpa_pkg.sv
sv/ccpa_if.sv
sv/ccpa_in_stage.sv
sv/ccpa_core.sv
sv/ccpa_out_stage.sv
sv/color_channel_period_averager.sv
sv/ccpa_checker.sv
verif/tb.sv
